[design/tpsl_pkg.sv]
// ----------------------------------------------------------------------------
// tpsl_pkg
// Shared types and constants for the transmit power setting lookup: the
// level ladder, table lane codes, request and register codes.
// ----------------------------------------------------------------------------
package tpsl_pkg;

  localparam int unsigned LEVELS     = 16;
  localparam int unsigned LEVEL_W    = $clog2(LEVELS);
  localparam int unsigned NUM_TABLES = 6;
  localparam int unsigned ENTRY_W    = 8;
  localparam int unsigned ROW_W      = NUM_TABLES * ENTRY_W;
  localparam int unsigned POWER_W    = 16;
  localparam int unsigned GRANT_W    = 13;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [POWER_W-1:0] power_t;
  typedef logic [GRANT_W-1:0] grant_t;
  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [NUM_TABLES-1:0] lane_mask_t;

  typedef enum logic {
    REQ_CONVERT = 1'b0,
    REQ_WRITE   = 1'b1
  } req_kind_t;

  typedef enum logic {
    BAND_HF  = 1'b0,
    BAND_VHF = 1'b1
  } band_t;

  typedef enum logic [2:0] {
    TBL_HF_POWER = 3'd0,
    TBL_AM_POWER = 3'd1,
    TBL_AM_HIGH  = 3'd2,
    TBL_AM_LOW   = 3'd3,
    TBL_CW_POWER = 3'd4,
    TBL_CW_DRIVE = 3'd5
  } table_sel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_HF_NORMAL  = 3'd0,
    CFG_MAX_HF_LOW     = 3'd1,
    CFG_MAX_VHF_NORMAL = 3'd2,
    CFG_MAX_VHF_LOW    = 3'd3,
    CFG_BATTERY_4V2    = 3'd4,
    CFG_HF_DRIVE_CAP   = 3'd5,
    CFG_VHF_BIAS_FLOOR = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    power_t max_hf_normal;
    power_t max_hf_low;
    power_t max_vhf_normal;
    power_t max_vhf_low;
    logic   battery_4v2;
    entry_t hf_drive_cap;
    entry_t vhf_bias_floor;
  } cfg_t;

  localparam power_t DEFAULT_CEILING = 16'd5000;
  localparam entry_t DEFAULT_HF_CAP  = 8'd255;
  localparam entry_t DEFAULT_FLOOR   = 8'd0;

  localparam power_t LADDER_LIMIT [LEVELS-1] = '{
    16'd5,    16'd50,   16'd150,  16'd250,  16'd350,  16'd450,  16'd550, 16'd650,
    16'd900,  16'd1250, 16'd1750, 16'd2250, 16'd2750, 16'd3500, 16'd4500
  };

  localparam grant_t LADDER_POWER [LEVELS] = '{
    13'd0,    13'd10,   13'd100,  13'd200,  13'd300,  13'd400,  13'd500,  13'd600,
    13'd800,  13'd1000, 13'd1500, 13'd2000, 13'd2500, 13'd3000, 13'd4000, 13'd5000
  };

  function automatic level_t level_of(input power_t p);
    level_t lvl;
    lvl = '0;
    for (int i = 0; i < LEVELS - 1; i++) begin
      if (p >= LADDER_LIMIT[i]) begin
        lvl = level_t'(i + 1);
      end
    end
    return lvl;
  endfunction

  function automatic entry_t lane(input row_t row, input table_sel_t sel);
    return row[sel*ENTRY_W +: ENTRY_W];
  endfunction

endpackage

[design/tpsl_intf.sv]
// ----------------------------------------------------------------------------
// tpsl channel interfaces
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tpsl_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] req_power;
  logic        band;
  logic        am_mode;
  logic [2:0]  table_select;
  logic [3:0]  entry_index;
  logic [7:0]  entry_value;

  modport source (output valid, req_type, req_power, band, am_mode, table_select,
                  entry_index, entry_value, input ready);
  modport sink (input valid, req_type, req_power, band, am_mode, table_select,
                entry_index, entry_value, output ready);
endinterface

interface tpsl_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  drive_level;
  logic [7:0]  mod_high;
  logic [7:0]  mod_low;
  logic [12:0] granted_power;
  logic [3:0]  level_index;
  logic        status;

  modport source (output valid, drive_level, mod_high, mod_low, granted_power,
                  level_index, status, input ready);
  modport sink (input valid, drive_level, mod_high, mod_low, granted_power,
                level_index, status, output ready);
endinterface

interface tpsl_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/tpsl_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tpsl_cfg_regs
// Register file for power ceilings, battery select, drive cap and bias floor.
// ----------------------------------------------------------------------------
module tpsl_cfg_regs
  import tpsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  tpsl_cfg_if.sink    cfg,
  output cfg_t        regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.max_hf_normal  <= DEFAULT_CEILING;
      regs.max_hf_low     <= DEFAULT_CEILING;
      regs.max_vhf_normal <= DEFAULT_CEILING;
      regs.max_vhf_low    <= DEFAULT_CEILING;
      regs.battery_4v2    <= 1'b0;
      regs.hf_drive_cap   <= DEFAULT_HF_CAP;
      regs.vhf_bias_floor <= DEFAULT_FLOOR;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_MAX_HF_NORMAL:  regs.max_hf_normal  <= cfg.data;
        CFG_MAX_HF_LOW:     regs.max_hf_low     <= cfg.data;
        CFG_MAX_VHF_NORMAL: regs.max_vhf_normal <= cfg.data;
        CFG_MAX_VHF_LOW:    regs.max_vhf_low    <= cfg.data;
        CFG_BATTERY_4V2:    regs.battery_4v2    <= cfg.data[0];
        CFG_HF_DRIVE_CAP:   regs.hf_drive_cap   <= cfg.data[ENTRY_W-1:0];
        CFG_VHF_BIAS_FLOOR: regs.vhf_bias_floor <= cfg.data[ENTRY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[design/tpsl_table_mem.sv]
// ----------------------------------------------------------------------------
// tpsl_table_mem
// Six byte tables side by side in one 16-row memory: per-lane write enables,
// one registered read port.
// ----------------------------------------------------------------------------
module tpsl_table_mem
  import tpsl_pkg::*;
(
  input  logic       clk,
  input  logic       we,
  input  lane_mask_t wlanes,
  input  level_t     waddr,
  input  entry_t     wdata,
  input  logic       re,
  input  level_t     raddr,
  output row_t       rdata
);

  row_t mem [LEVELS];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < NUM_TABLES; i++) begin
        if (wlanes[i]) begin
          mem[waddr][i*ENTRY_W +: ENTRY_W] <= wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/tx_power_setting_lookup.sv]
// ----------------------------------------------------------------------------
// tx_power_setting_lookup
// Takes one beat per cycle while the response side keeps up. The edge that
// accepts a conversion beat clamps it to the band and battery ceiling, places
// it on the 16-level ladder and reads the table row into stage 1; when the
// output stage advances, it applies the drive cap or bias floor into the
// output register and the response goes valid. The row stage exists as
// the table memory's read is registered. A held response stalls the input
// only once the row stage behind it is full as well. Table write beats
// update one byte lane and yield no response; table select codes 6 and 7
// are dropped. Register writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
module tx_power_setting_lookup
  import tpsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  tpsl_req_if.sink    req,
  tpsl_rsp_if.source  rsp,
  tpsl_cfg_if.sink    cfg
);

  cfg_t       regs;
  logic       accept;
  logic       is_convert;
  logic       advance;
  power_t     ceiling;
  power_t     clamped;
  logic       over;
  level_t     level;
  lane_mask_t wlanes;
  row_t       row;

  logic       s1_valid;
  level_t     s1_level;
  logic       s1_status;
  logic       s1_band;
  logic       s1_am;

  entry_t     drive_next;
  entry_t     high_next;
  entry_t     low_next;

  logic       rsp_valid;
  entry_t     drive;
  entry_t     mod_high;
  entry_t     mod_low;
  grant_t     granted;
  level_t     level_out;
  logic       status;

  tpsl_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign advance    = !rsp_valid || rsp.ready;
  assign req.ready  = !s1_valid || advance;
  assign accept     = req.valid && req.ready;
  assign is_convert = (req.req_type == REQ_CONVERT);

  always_comb begin
    if (req.band == BAND_VHF) begin
      ceiling = regs.battery_4v2 ? regs.max_vhf_low : regs.max_vhf_normal;
    end else begin
      ceiling = regs.battery_4v2 ? regs.max_hf_low : regs.max_hf_normal;
    end
    over    = (req.req_power > ceiling);
    clamped = over ? ceiling : req.req_power;
    level   = level_of(clamped);
  end

  always_comb begin
    case (req.table_select)
      TBL_HF_POWER: wlanes = lane_mask_t'(1) << TBL_HF_POWER;
      TBL_AM_POWER: wlanes = lane_mask_t'(1) << TBL_AM_POWER;
      TBL_AM_HIGH:  wlanes = lane_mask_t'(1) << TBL_AM_HIGH;
      TBL_AM_LOW:   wlanes = lane_mask_t'(1) << TBL_AM_LOW;
      TBL_CW_POWER: wlanes = lane_mask_t'(1) << TBL_CW_POWER;
      TBL_CW_DRIVE: wlanes = lane_mask_t'(1) << TBL_CW_DRIVE;
      default:      wlanes = '0;
    endcase
  end

  tpsl_table_mem u_mem (
    .clk    (clk),
    .we     (accept && !is_convert),
    .wlanes (wlanes),
    .waddr  (req.entry_index),
    .wdata  (req.entry_value),
    .re     (accept && is_convert),
    .raddr  (level),
    .rdata  (row)
  );

  // stage 1: level and flags, row arrives from the memory
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= accept && is_convert;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_convert) begin
      s1_level  <= level;
      s1_status <= over;
      s1_band   <= req.band;
      s1_am     <= req.am_mode;
    end
  end

  always_comb begin
    if (s1_band == BAND_VHF) begin
      if (s1_am) begin
        drive_next = lane(row, TBL_AM_POWER);
        high_next  = lane(row, TBL_AM_HIGH);
        low_next   = lane(row, TBL_AM_LOW);
      end else begin
        drive_next = lane(row, TBL_CW_POWER);
        high_next  = lane(row, TBL_CW_DRIVE);
        low_next   = lane(row, TBL_CW_DRIVE);
      end
      if (drive_next < regs.vhf_bias_floor) begin
        drive_next = regs.vhf_bias_floor;
      end
    end else begin
      drive_next = lane(row, TBL_HF_POWER);
      if (drive_next > regs.hf_drive_cap) begin
        drive_next = regs.hf_drive_cap;
      end
      high_next = '0;
      low_next  = '0;
    end
  end

  // stage 2: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      drive     <= drive_next;
      mod_high  <= high_next;
      mod_low   <= low_next;
      granted   <= LADDER_POWER[s1_level];
      level_out <= s1_level;
      status    <= s1_status;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.drive_level   = drive;
  assign rsp.mod_high      = mod_high;
  assign rsp.mod_low       = mod_low;
  assign rsp.granted_power = granted;
  assign rsp.level_index   = level_out;
  assign rsp.status        = status;

  a_convert_enters_stage1: assert property (@(posedge clk) disable iff (rst)
    accept && is_convert |=> s1_valid)
    else $error("conversion beat did not reach stage 1");

  a_write_leaves_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && !is_convert |=> !s1_valid)
    else $error("table write beat produced a pending result");

  a_stage1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_level) && $stable(row))
    else $error("stage 1 changed while stalled");

  a_stage1_to_output: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance |=> rsp_valid && (level_out == $past(s1_level)))
    else $error("stage 1 result lost on advance");

endmodule

[sim/tb_tx_power_setting_lookup.sv]
// ----------------------------------------------------------------------------
// tb_tx_power_setting_lookup
// Self-checking bench for the transmit power setting lookup. Table write
// beats and conversion beats go in through the request channel. A local
// scoreboard tracks the ceilings, the drive cap, the bias floor and the six
// level tables, and predicts drive, modulation levels, level, granted power
// and clamp status for each conversion. Each response beat is compared
// field by field. The bench loads every table entry before a conversion can
// read it. It runs a directed part and then random phases under several
// register settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_tx_power_setting_lookup
  import tpsl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] SEL_BAD_LO    = 3'd6;
  localparam logic [2:0] SEL_BAD_HI    = 3'd7;
  localparam int         SETTLE_CYCLES = 4;
  localparam int         END_CYCLES    = 8;
  localparam int         PHASES        = 8;
  localparam int         PHASE_ITEMS   = 62;

  typedef struct packed {
    req_kind_t  kind;
    power_t     power;
    band_t      band;
    logic       am;
    logic [2:0] sel;
    level_t     idx;
    entry_t     val;
  } req_beat_t;

  typedef struct packed {
    entry_t drive;
    entry_t mod_hi;
    entry_t mod_lo;
    grant_t grant;
    level_t lvl;
    logic   clamped;
  } setting_t;

  class power_lookup_scoreboard;
    cfg_t     regs;
    entry_t   tbl    [NUM_TABLES][LEVELS];
    bit       loaded [NUM_TABLES][LEVELS];
    setting_t pending[$];
    int       errors;

    function void clear();
      regs.max_hf_normal  = DEFAULT_CEILING;
      regs.max_hf_low     = DEFAULT_CEILING;
      regs.max_vhf_normal = DEFAULT_CEILING;
      regs.max_vhf_low    = DEFAULT_CEILING;
      regs.battery_4v2    = 1'b0;
      regs.hf_drive_cap   = DEFAULT_HF_CAP;
      regs.vhf_bias_floor = DEFAULT_FLOOR;
      foreach (loaded[t, i]) begin
        loaded[t][i] = 1'b0;
        tbl[t][i]    = '0;
      end
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t r, logic [15:0] d);
      case (r)
        CFG_MAX_HF_NORMAL:  regs.max_hf_normal  = d;
        CFG_MAX_HF_LOW:     regs.max_hf_low     = d;
        CFG_MAX_VHF_NORMAL: regs.max_vhf_normal = d;
        CFG_MAX_VHF_LOW:    regs.max_vhf_low    = d;
        CFG_BATTERY_4V2:    regs.battery_4v2    = d[0];
        CFG_HF_DRIVE_CAP:   regs.hf_drive_cap   = d[7:0];
        CFG_VHF_BIAS_FLOOR: regs.vhf_bias_floor = d[7:0];
        default: ;
      endcase
    endfunction

    function power_t ceiling_for(band_t b);
      if (b == BAND_VHF) begin
        return regs.battery_4v2 ? regs.max_vhf_low : regs.max_vhf_normal;
      end
      return regs.battery_4v2 ? regs.max_hf_low : regs.max_hf_normal;
    endfunction

    function level_t rung_of(power_t p);
      level_t lvl;
      lvl = '0;
      for (int k = 0; k < LEVELS - 1; k++) begin
        if (p < LADDER_LIMIT[k]) break;
        lvl++;
      end
      return lvl;
    endfunction

    function void note_request(req_beat_t b);
      setting_t want;
      power_t   ceil_mw;
      power_t   p;
      if (b.kind == REQ_WRITE) begin
        if (b.sel < NUM_TABLES) begin
          tbl[b.sel][b.idx]    = b.val;
          loaded[b.sel][b.idx] = 1'b1;
        end
        return;
      end
      ceil_mw      = ceiling_for(b.band);
      want.clamped = (b.power > ceil_mw);
      p            = want.clamped ? ceil_mw : b.power;
      want.lvl     = rung_of(p);
      want.grant   = LADDER_POWER[want.lvl];
      if (b.band == BAND_HF) begin
        want.drive  = tbl[TBL_HF_POWER][want.lvl];
        if (want.drive > regs.hf_drive_cap) want.drive = regs.hf_drive_cap;
        want.mod_hi = '0;
        want.mod_lo = '0;
      end else begin
        if (b.am) begin
          want.drive  = tbl[TBL_AM_POWER][want.lvl];
          want.mod_hi = tbl[TBL_AM_HIGH][want.lvl];
          want.mod_lo = tbl[TBL_AM_LOW][want.lvl];
        end else begin
          want.drive  = tbl[TBL_CW_POWER][want.lvl];
          want.mod_hi = tbl[TBL_CW_DRIVE][want.lvl];
          want.mod_lo = want.mod_hi;
        end
        if (want.drive < regs.vhf_bias_floor) want.drive = regs.vhf_bias_floor;
      end
      pending.push_back(want);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_response(setting_t got);
      setting_t want;
      if (pending.size() == 0) begin
        $error("response with nothing pending: drive %0d level %0d", got.drive, got.lvl);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare("drive_level", want.drive, got.drive);
      compare("mod_high", want.mod_hi, got.mod_hi);
      compare("mod_low", want.mod_lo, got.mod_lo);
      compare("granted_power", want.grant, got.grant);
      compare("level_index", want.lvl, got.lvl);
      compare("status", want.clamped, got.clamped);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  tpsl_req_if req_ch ();
  tpsl_rsp_if rsp_ch ();
  tpsl_cfg_if cfg_ch ();

  power_lookup_scoreboard sb;
  bit steady;
  int items_sent;

  tx_power_setting_lookup u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic power_t pick_power(band_t b);
    int     r;
    power_t ceil_mw;
    ceil_mw = sb.ceiling_for(b);
    r = $urandom_range(0, 99);
    if (r < 40) return power_t'(LADDER_LIMIT[$urandom_range(0, LEVELS - 2)] - $urandom_range(0, 1));
    if (r < 55) return power_t'(ceil_mw + $urandom_range(0, 2) - 1);
    if (r < 80) return power_t'($urandom_range(0, 5200));
    return power_t'($urandom);
  endfunction

  function automatic power_t pick_ceiling();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return 16'hFFFF;
    if (r < 50) return DEFAULT_CEILING;
    return power_t'($urandom_range(0, 6000));
  endfunction

  function automatic entry_t pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 40) return 8'hFF;
    return entry_t'($urandom);
  endfunction

  function automatic cfg_t random_setting();
    cfg_t s;
    s.max_hf_normal  = pick_ceiling();
    s.max_hf_low     = pick_ceiling();
    s.max_vhf_normal = pick_ceiling();
    s.max_vhf_low    = pick_ceiling();
    s.battery_4v2    = 1'($urandom_range(0, 1));
    s.hf_drive_cap   = pick_byte();
    s.vhf_bias_floor = pick_byte();
    return s;
  endfunction

  function automatic lane_mask_t lanes_read(band_t b, logic am);
    lane_mask_t m;
    m = '0;
    if (b == BAND_HF) begin
      m[TBL_HF_POWER] = 1'b1;
    end else if (am) begin
      m[TBL_AM_POWER] = 1'b1;
      m[TBL_AM_HIGH]  = 1'b1;
      m[TBL_AM_LOW]   = 1'b1;
    end else begin
      m[TBL_CW_POWER] = 1'b1;
      m[TBL_CW_DRIVE] = 1'b1;
    end
    return m;
  endfunction

  function automatic req_beat_t random_beat();
    req_beat_t b;
    b.kind  = req_kind_t'($urandom_range(0, 1));
    b.power = power_t'($urandom);
    b.band  = band_t'($urandom_range(0, 1));
    b.am    = 1'($urandom_range(0, 1));
    b.sel   = 3'($urandom);
    b.idx   = level_t'($urandom);
    b.val   = entry_t'($urandom);
    return b;
  endfunction

  task automatic send_beat(input req_beat_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= b.kind;
    req_ch.req_power    <= b.power;
    req_ch.band         <= b.band;
    req_ch.am_mode      <= b.am;
    req_ch.table_select <= b.sel;
    req_ch.entry_index  <= b.idx;
    req_ch.entry_value  <= b.val;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(b);
    if (!(b.kind == REQ_WRITE && b.sel >= NUM_TABLES)) items_sent++;
  endtask

  task automatic send_write(input logic [2:0] sel, input level_t idx, input entry_t val);
    req_beat_t b;
    b      = random_beat();
    b.kind = REQ_WRITE;
    b.sel  = sel;
    b.idx  = idx;
    b.val  = val;
    send_beat(b);
  endtask

  task automatic convert(input power_t p, input band_t band, input logic am);
    req_beat_t  b;
    power_t     ceil_mw;
    level_t     lvl;
    lane_mask_t need;
    ceil_mw = sb.ceiling_for(band);
    lvl     = sb.rung_of((p > ceil_mw) ? ceil_mw : p);
    need    = lanes_read(band, am);
    // load every entry this conversion reads
    for (int t = 0; t < NUM_TABLES; t++) begin
      if (need[t] && !sb.loaded[t][lvl]) send_write(3'(t), lvl, entry_t'($urandom));
    end
    b       = random_beat();
    b.kind  = REQ_CONVERT;
    b.power = p;
    b.band  = band;
    b.am    = am;
    send_beat(b);
  endtask

  task automatic random_item();
    int    pick;
    band_t band;
    pick = $urandom_range(0, 99);
    band = band_t'($urandom_range(0, 1));
    if (pick < 55) begin
      convert(pick_power(band), band, 1'($urandom_range(0, 1)));
    end else if (pick < 92) begin
      send_write(3'($urandom_range(0, NUM_TABLES - 1)), level_t'($urandom), entry_t'($urandom));
    end else begin
      send_write($urandom_range(0, 1) ? SEL_BAD_HI : SEL_BAD_LO, level_t'($urandom),
                 entry_t'($urandom));
    end
  endtask

  task automatic drain(input int settle);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t r, input logic [15:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data  <= d;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.write_reg(r, d);
  endtask

  task automatic apply_setting(input cfg_t s);
    cfg_write(CFG_MAX_HF_NORMAL, s.max_hf_normal);
    cfg_write(CFG_MAX_HF_LOW, s.max_hf_low);
    cfg_write(CFG_MAX_VHF_NORMAL, s.max_vhf_normal);
    cfg_write(CFG_MAX_VHF_LOW, s.max_vhf_low);
    cfg_write(CFG_BATTERY_4V2, 16'(s.battery_4v2));
    cfg_write(CFG_HF_DRIVE_CAP, 16'(s.hf_drive_cap));
    cfg_write(CFG_VHF_BIAS_FLOOR, 16'(s.vhf_bias_floor));
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : rsp_side
    int       hold;
    int       gap;
    setting_t got;
    hold = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        got.drive   = rsp_ch.drive_level;
        got.mod_hi  = rsp_ch.mod_high;
        got.mod_lo  = rsp_ch.mod_low;
        got.grant   = rsp_ch.granted_power;
        got.lvl     = rsp_ch.level_index;
        got.clamped = rsp_ch.status;
        sb.check_response(got);
      end
      if (hold > 0) begin
        hold--;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          rsp_ch.ready <= 1'b1;
        end else begin
          rsp_ch.ready <= 1'b0;
          hold = gap - 1;
        end
      end
    end
  end

  initial begin : stimulus
    cfg_t setting;
    int   goal;
    sb = new;
    sb.clear();
    steady     = 1'b0;
    items_sent = 0;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= REQ_CONVERT;
    req_ch.req_power    <= '0;
    req_ch.band         <= BAND_HF;
    req_ch.am_mode      <= 1'b0;
    req_ch.table_select <= TBL_HF_POWER;
    req_ch.entry_index  <= '0;
    req_ch.entry_value  <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_MAX_HF_NORMAL;
    cfg_ch.data         <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part under reset values
    send_write(SEL_BAD_LO, 4'd3, 8'hA5);
    send_write(SEL_BAD_HI, 4'd15, 8'hFF);
    send_write(TBL_HF_POWER, 4'd0, 8'h00);
    convert(16'd0, BAND_HF, 1'b0);
    send_write(TBL_HF_POWER, 4'd0, 8'hFF);
    convert(16'd4, BAND_HF, 1'b0);
    convert(16'hFFFF, BAND_HF, 1'b0);
    convert(16'd5000, BAND_HF, 1'b1);
    convert(16'd4, BAND_VHF, 1'b1);
    convert(16'd5, BAND_VHF, 1'b1);
    convert(16'd4499, BAND_VHF, 1'b0);
    convert(16'd4500, BAND_VHF, 1'b0);
    convert(16'd5001, BAND_VHF, 1'b0);

    // zero ceilings, low battery, tightest cap and floor
    drain(SETTLE_CYCLES);
    setting = '{16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 8'h00, 8'hFF};
    apply_setting(setting);
    convert(16'hFFFF, BAND_HF, 1'b0);
    convert(16'd1, BAND_VHF, 1'b1);
    convert(16'd0, BAND_VHF, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain(SETTLE_CYCLES);
      case (ph)
        0: setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 8'hFF, 8'h00};
        1: setting = '{DEFAULT_CEILING, 16'd900, 16'd3000, 16'd4500, 1'b1, 8'h00, 8'hFF};
        default: setting = random_setting();
      endcase
      apply_setting(setting);
      steady = (ph % 3 == 2);
      goal   = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        random_item();
        // hold the sender until all pending responses are back
        if ($urandom_range(0, 199) == 0) drain(0);
      end
    end

    drain(END_CYCLES);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

[tx_power_setting_lookup.f]
design/tpsl_pkg.sv
design/tpsl_intf.sv
design/tpsl_cfg_regs.sv
design/tpsl_table_mem.sv
design/tx_power_setting_lookup.sv
sim/tb_tx_power_setting_lookup.sv
